FILE: rtl/b64c_pkg.sv
package b64c_pkg;

	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChUpperZ = 8'h5A;
	localparam logic [7:0] ChLowerA = 8'h61;
	localparam logic [7:0] ChLowerZ = 8'h7A;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChPad    = 8'h3D;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChCr     = 8'h0D;

	localparam logic ModeEncode = 1'b0;
	localparam logic ModeDecode = 1'b1;

	// stream state carried between items
	typedef struct packed {
		logic [15:0] bits;
		logic [3:0]  count;
		logic        stopped;
	} b64c_state_t;

	// results caused by one item
	typedef struct packed {
		logic            any;
		logic [1:0]      last_idx;
		logic [3:0][7:0] chars;
	} b64c_result_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} b64c_sextet_t;

	// six-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return ChUpperA + w;
		end else if (v < 6'd52) begin
			return ChLowerA + w - 8'd26;
		end else if (v < 6'd62) begin
			return ChZero + w - 8'd52;
		end else if (v == 6'd62) begin
			return ChPlus;
		end else begin
			return ChSlash;
		end
	endfunction

	// alphabet character to six-bit value
	function automatic b64c_sextet_t char_value(input logic [7:0] c);
		b64c_sextet_t r;
		r.ok = 1'b1;
		r.val = 6'd0;
		if (c >= ChUpperA && c <= ChUpperZ) begin
			r.val = 6'(c - ChUpperA);
		end else if (c >= ChLowerA && c <= ChLowerZ) begin
			r.val = 6'(c - ChLowerA + 8'd26);
		end else if (c >= ChZero && c <= ChNine) begin
			r.val = 6'(c - ChZero + 8'd52);
		end else if (c == ChPlus) begin
			r.val = 6'd62;
		end else if (c == ChSlash) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/b64c_step.sv
module b64c_step (
	input  logic                  mode,
	input  b64c_pkg::b64c_state_t cur,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output b64c_pkg::b64c_state_t nxt,
	output b64c_pkg::b64c_result_t res
);
	import b64c_pkg::*;

	logic [23:0]  v;
	logic [15:0]  pb;
	logic [3:0]   cnt;
	logic [2:0]   rem;
	b64c_sextet_t sx;

	always_comb begin
		nxt = cur;
		res = '0;
		v = '0;
		pb = '0;
		cnt = '0;
		rem = '0;
		sx = char_value(in_byte);
		if (mode == ModeEncode) begin
			if (cur.count[1:0] >= 2'd2) begin
				// full group of three
				v = {cur.bits, in_byte};
				res.any = 1'b1;
				res.last_idx = 2'd3;
				res.chars[0] = enc_char(v[23:18]);
				res.chars[1] = enc_char(v[17:12]);
				res.chars[2] = enc_char(v[11:6]);
				res.chars[3] = enc_char(v[5:0]);
				nxt.bits = '0;
				nxt.count = '0;
			end else begin
				nxt.bits = {cur.bits[7:0], in_byte};
				nxt.count = {2'b00, cur.count[1:0] + 2'd1};
				if (in_last) begin
					res.any = 1'b1;
					res.last_idx = 2'd3;
					if (cur.count[1:0] == 2'd0) begin
						v = {in_byte, 16'h0000};
						res.chars[2] = ChPad;
					end else begin
						v = {cur.bits[7:0], in_byte, 8'h00};
						res.chars[2] = enc_char(v[11:6]);
					end
					res.chars[0] = enc_char(v[23:18]);
					res.chars[1] = enc_char(v[17:12]);
					res.chars[3] = ChPad;
				end
			end
		end else begin
			if (cur.stopped) begin
				// ignore everything after padding
			end else if (in_byte == ChPad) begin
				nxt.stopped = 1'b1;
			end else if (in_byte == ChLf || in_byte == ChCr || in_byte[7]) begin
				// skipped
			end else if (sx.ok) begin
				cnt = {1'b0, cur.count[2:0]} + 4'd6;
				pb = {cur.bits[9:0], sx.val};
				if (cnt >= 4'd8) begin
					rem = 3'(cnt - 4'd8);
					res.any = 1'b1;
					res.last_idx = 2'd0;
					res.chars[0] = 8'(pb >> rem);
					nxt.count = {1'b0, rem};
					nxt.bits = pb & ((16'd1 << rem) - 16'd1);
				end else begin
					nxt.count = cnt;
					nxt.bits = pb;
				end
			end
		end
		if (in_last) begin
			nxt = '0;
		end
	end

endmodule

FILE: rtl/base64_codec.sv
// streaming base64 codec, one byte per input beat
// the first result beat appears in the cycle after the input beat is taken
// throughput: one input beat per cycle while each causes at most one result and the
// output does not stall, else bound by the output at one result beat per cycle
// (four per encoded group); reset: arst_n asynchronous active low, clears mode to
// encode, the stream state and the valid flag of the result register
module base64_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import b64c_pkg::*;

	// mode register and stream state
	logic         mode_q;
	b64c_state_t  state_q;
	b64c_state_t  state_nxt;
	b64c_result_t res;

	// result register: one group of up to four beats
	logic            grp_valid_s1;
	logic [1:0]      grp_last_s1;
	logic [3:0][7:0] grp_chars_s1;
	logic [1:0]      idx_q;

	logic out_take;
	logic last_beat;
	logic in_take;

	b64c_step u_step (
		.mode    (mode_q),
		.cur     (state_q),
		.in_byte (in_byte),
		.in_last (in_last),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign cfg_ready = 1'b1;

	assign out_valid = grp_valid_s1;
	assign out_byte  = grp_chars_s1[idx_q];
	assign out_last  = (idx_q == grp_last_s1);

	assign out_take  = out_valid && !out_stall;
	assign last_beat = out_take && out_last;
	// an item without results always passes, one with results waits until the
	// result register is empty or its last beat leaves
	assign in_stall  = grp_valid_s1 && !last_beat && res.any;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeEncode;
			state_q <= '0;
			grp_valid_s1 <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// a mode write restarts the stream
				mode_q <= cfg_data;
				state_q <= '0;
			end else if (in_take) begin
				state_q <= state_nxt;
			end
			if (in_take && res.any) begin
				grp_valid_s1 <= 1'b1;
				idx_q <= '0;
			end else if (last_beat) begin
				grp_valid_s1 <= 1'b0;
				idx_q <= '0;
			end else if (out_take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// payload of the result register, no reset needed
	always_ff @(posedge clk) begin
		if (in_take && res.any) begin
			grp_last_s1 <= res.last_idx;
			grp_chars_s1 <= res.chars;
		end
	end

endmodule

FILE: rtl/b64c_checker.sv
module b64c_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled result beat changed");

	// input is never stalled while no result is pending
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// the last beat of a group leaving frees the input
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && out_valid && !out_stall && out_last |-> !in_stall)
		else $error("input stalled while the last beat of a group leaves");

	// a group keeps its beats coming until its last one
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_last |=> out_valid)
		else $error("group ended without a last beat");

endmodule

bind base64_codec b64c_checker u_b64c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.out_last  (out_last)
);
